// File: sv/bfm_pkg.sv
// ----------------------------------------------------------------------------
// bfm_pkg: shared constants for the tape-language machine
// Holds the command bytes, request operations and result status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package bfm_pkg;

  // Request operations.
  localparam logic [1:0] OPN_LOAD    = 2'd0;
  localparam logic [1:0] OPN_RUN     = 2'd1;
  localparam logic [1:0] OPN_SUPPLY  = 2'd2;
  localparam logic [1:0] OPN_RESTART = 2'd3;

  // Command bytes of the language.
  localparam logic [7:0] CMD_RIGHT = 8'h3E;
  localparam logic [7:0] CMD_LEFT  = 8'h3C;
  localparam logic [7:0] CMD_INC   = 8'h2B;
  localparam logic [7:0] CMD_DEC   = 8'h2D;
  localparam logic [7:0] CMD_PRINT = 8'h2E;
  localparam logic [7:0] CMD_READ  = 8'h2C;
  localparam logic [7:0] CMD_OPEN  = 8'h5B;
  localparam logic [7:0] CMD_CLOSE = 8'h5D;

  // Result status codes.
  localparam logic [2:0] STS_OUTPUT   = 3'd0;
  localparam logic [2:0] STS_NEED_IN  = 3'd1;
  localparam logic [2:0] STS_FINISHED = 3'd2;
  localparam logic [2:0] STS_PTR_OOR  = 3'd3;
  localparam logic [2:0] STS_UNMATCH  = 3'd4;
  localparam logic [2:0] STS_BUDGET   = 3'd5;
  localparam logic [2:0] STS_ACCEPTED = 3'd6;
  localparam logic [2:0] STS_CODE_FULL = 3'd7;

  // Step budget register and the cap on an unbudgeted run.
  localparam int unsigned BUDGET_W = 24;
  localparam int unsigned COUNT_W  = BUDGET_W + 1;
  localparam logic [COUNT_W-1:0] FULL_SPAN = {1'b1, {BUDGET_W{1'b0}}};

endpackage

`default_nettype wire

// File: sv/bfm_ram.sv
// ----------------------------------------------------------------------------
// bfm_ram: simple dual-port synchronous memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bfm_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata_r
);

  logic [7:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/brainfuck_machine_core_top.sv
// ----------------------------------------------------------------------------
// brainfuck_machine_core_top: tape-language machine core
// Code and tape live in synchronous memories; a sequencer fetches, executes
// and scans brackets, keeping the current cell in a register.
// ----------------------------------------------------------------------------
// A load request goes straight to the response; a supply request passes
// through the supply state first unless the code has ended. A run request
// fetches and executes each instruction, with a tape load for a pointer move,
// and reads one code byte at a time in a bracket scan. Restart sweeps the
// tape one cell per cycle. After reset the same clearing pass runs while
// in_stall is high; the step budget register resets to zero.
`default_nettype none

module brainfuck_machine_core_top #(
  parameter int unsigned CODE_DEPTH = 4096,
  parameter int unsigned TAPE_CELLS = 32768
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   in_operation,
  input  wire logic [7:0]                   in_data_byte,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [2:0]                   out_status,
  output logic      [7:0]                   out_byte,
  input  wire logic                         cfg_we,
  input  wire logic [bfm_pkg::BUDGET_W-1:0] cfg_wdata
);

  localparam int unsigned CA = $clog2(CODE_DEPTH);
  localparam int unsigned LW = $clog2(CODE_DEPTH + 1);
  localparam int unsigned TA = $clog2(TAPE_CELLS);
  localparam int unsigned CW = bfm_pkg::COUNT_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FETCH = 4'd1;
  localparam logic [3:0] S_EXEC  = 4'd2;
  localparam logic [3:0] S_TLOAD = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_SCANE = 4'd5;
  localparam logic [3:0] S_SUP   = 4'd6;
  localparam logic [3:0] S_CLEAR = 4'd7;
  localparam logic [3:0] S_RESP  = 4'd8;

  localparam logic [TA-1:0] TAPE_LAST = TA'(TAPE_CELLS - 1);
  localparam logic [LW-1:0] CODE_FULL = LW'(CODE_DEPTH);

  logic [3:0]                   state_r, state_nxt;
  logic [LW-1:0]                len_r, len_nxt;
  logic [LW-1:0]                ip_r, ip_nxt;
  logic [TA-1:0]                tp_r, tp_nxt;
  logic [LW-1:0]                depth_r, depth_nxt;
  logic [LW-1:0]                j_r, j_nxt;
  logic                         bwd_r, bwd_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic [7:0]                   cell_r, cell_nxt;
  logic [7:0]                   data_r, data_nxt;
  logic [TA-1:0]                clr_r, clr_nxt;
  logic                         clr_resp_r, clr_resp_nxt;
  logic [2:0]                   res_sts_r, res_sts_nxt;
  logic [7:0]                   res_byte_r, res_byte_nxt;
  logic [bfm_pkg::BUDGET_W-1:0] budget_r;
  logic                         out_valid_r;
  logic [2:0]                   out_status_r;
  logic [7:0]                   out_byte_r;

  logic [CW-1:0] limit;
  logic          out_load;

  logic          pw_en;
  logic [CA-1:0] pw_addr;
  logic [CA-1:0] pr_addr;
  logic [7:0]    pr_data;
  logic          tw_en;
  logic [TA-1:0] tw_addr;
  logic [7:0]    tw_data;
  logic [TA-1:0] tr_addr;
  logic [7:0]    tr_data;

  // Code memory and tape memory.
  bfm_ram #(.DEPTH(CODE_DEPTH), .AW(CA)) u_code (
    .clk(clk), .we(pw_en), .waddr(pw_addr), .wdata(in_data_byte),
    .raddr(pr_addr), .rdata_r(pr_data)
  );

  bfm_ram #(.DEPTH(TAPE_CELLS), .AW(TA)) u_tape (
    .clk(clk), .we(tw_en), .waddr(tw_addr), .wdata(tw_data),
    .raddr(tr_addr), .rdata_r(tr_data)
  );

  assign limit    = (budget_r == '0) ? bfm_pkg::FULL_SPAN : {1'b0, budget_r};
  assign in_stall = (state_r != S_IDLE);
  assign out_load = (state_r == S_RESP) && (!out_valid_r || !out_stall);

  // Sequencer: fetch, execute, bracket scan, supply and tape clearing.
  always_comb begin
    state_nxt    = state_r;
    len_nxt      = len_r;
    ip_nxt       = ip_r;
    tp_nxt       = tp_r;
    depth_nxt    = depth_r;
    j_nxt        = j_r;
    bwd_nxt      = bwd_r;
    cnt_nxt      = cnt_r;
    cell_nxt     = cell_r;
    data_nxt     = data_r;
    clr_nxt      = clr_r;
    clr_resp_nxt = clr_resp_r;
    res_sts_nxt  = res_sts_r;
    res_byte_nxt = res_byte_r;
    pw_en        = 1'b0;
    pw_addr      = len_r[CA-1:0];
    pr_addr      = ip_r[CA-1:0];
    tw_en        = 1'b0;
    tw_addr      = tp_r;
    tw_data      = cell_r;
    tr_addr      = tp_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_byte_nxt = 8'd0;
          res_sts_nxt  = bfm_pkg::STS_ACCEPTED;
          state_nxt    = S_RESP;
          unique case (in_operation)
            bfm_pkg::OPN_LOAD: begin
              if (len_r >= CODE_FULL) begin
                res_sts_nxt = bfm_pkg::STS_CODE_FULL;
              end else begin
                pw_en   = 1'b1;
                len_nxt = len_r + 1'b1;
              end
            end
            bfm_pkg::OPN_RUN: begin
              cnt_nxt   = '0;
              state_nxt = S_FETCH;
            end
            bfm_pkg::OPN_SUPPLY: begin
              data_nxt = in_data_byte;
              if (ip_r < len_r) begin
                state_nxt = S_SUP;
              end
            end
            default: begin
              clr_nxt      = '0;
              clr_resp_nxt = 1'b1;
              state_nxt    = S_CLEAR;
            end
          endcase
        end
      end

      S_FETCH: begin
        // End of code is checked ahead of the budget.
        if (ip_r >= len_r) begin
          res_sts_nxt = bfm_pkg::STS_FINISHED;
          state_nxt   = S_RESP;
        end else if (cnt_r >= limit) begin
          res_sts_nxt = bfm_pkg::STS_BUDGET;
          state_nxt   = S_RESP;
        end else begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_FETCH;
        unique case (pr_data)
          bfm_pkg::CMD_RIGHT: begin
            if (tp_r == TAPE_LAST) begin
              res_sts_nxt = bfm_pkg::STS_PTR_OOR;
              state_nxt   = S_RESP;
            end else begin
              tp_nxt    = tp_r + 1'b1;
              tr_addr   = tp_r + 1'b1;
              ip_nxt    = ip_r + 1'b1;
              cnt_nxt   = cnt_r + 1'b1;
              state_nxt = S_TLOAD;
            end
          end
          bfm_pkg::CMD_LEFT: begin
            if (tp_r == '0) begin
              res_sts_nxt = bfm_pkg::STS_PTR_OOR;
              state_nxt   = S_RESP;
            end else begin
              tp_nxt    = tp_r - 1'b1;
              tr_addr   = tp_r - 1'b1;
              ip_nxt    = ip_r + 1'b1;
              cnt_nxt   = cnt_r + 1'b1;
              state_nxt = S_TLOAD;
            end
          end
          bfm_pkg::CMD_INC: begin
            cell_nxt = cell_r + 8'd1;
            tw_en    = 1'b1;
            tw_data  = cell_r + 8'd1;
            ip_nxt   = ip_r + 1'b1;
            cnt_nxt  = cnt_r + 1'b1;
          end
          bfm_pkg::CMD_DEC: begin
            cell_nxt = cell_r - 8'd1;
            tw_en    = 1'b1;
            tw_data  = cell_r - 8'd1;
            ip_nxt   = ip_r + 1'b1;
            cnt_nxt  = cnt_r + 1'b1;
          end
          bfm_pkg::CMD_PRINT: begin
            ip_nxt       = ip_r + 1'b1;
            res_sts_nxt  = bfm_pkg::STS_OUTPUT;
            res_byte_nxt = cell_r;
            state_nxt    = S_RESP;
          end
          bfm_pkg::CMD_READ: begin
            res_sts_nxt = bfm_pkg::STS_NEED_IN;
            state_nxt   = S_RESP;
          end
          bfm_pkg::CMD_OPEN: begin
            if (cell_r != 8'd0) begin
              ip_nxt  = ip_r + 1'b1;
              cnt_nxt = cnt_r + 1'b1;
            end else begin
              depth_nxt = LW'(1);
              j_nxt     = ip_r + 1'b1;
              bwd_nxt   = 1'b0;
              state_nxt = S_SCAN;
            end
          end
          bfm_pkg::CMD_CLOSE: begin
            if (cell_r == 8'd0) begin
              ip_nxt  = ip_r + 1'b1;
              cnt_nxt = cnt_r + 1'b1;
            end else begin
              depth_nxt = LW'(1);
              j_nxt     = ip_r;
              bwd_nxt   = 1'b1;
              state_nxt = S_SCAN;
            end
          end
          default: begin
            ip_nxt  = ip_r + 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
        endcase
      end

      S_TLOAD: begin
        cell_nxt  = tr_data;
        state_nxt = S_FETCH;
      end

      S_SCAN: begin
        // Issue the next code read of the bracket search, or give up.
        if (!bwd_r) begin
          pr_addr = j_r[CA-1:0];
          if (j_r >= len_r) begin
            depth_nxt   = '0;
            res_sts_nxt = bfm_pkg::STS_UNMATCH;
            state_nxt   = S_RESP;
          end else begin
            state_nxt = S_SCANE;
          end
        end else begin
          pr_addr = CA'(j_r - 1'b1);
          if (j_r == '0) begin
            depth_nxt   = '0;
            res_sts_nxt = bfm_pkg::STS_UNMATCH;
            state_nxt   = S_RESP;
          end else begin
            j_nxt     = j_r - 1'b1;
            state_nxt = S_SCANE;
          end
        end
      end

      S_SCANE: begin
        state_nxt = S_SCAN;
        if (!bwd_r) begin
          j_nxt = j_r + 1'b1;
        end
        if ((!bwd_r && pr_data == bfm_pkg::CMD_OPEN) ||
            (bwd_r && pr_data == bfm_pkg::CMD_CLOSE)) begin
          depth_nxt = depth_r + 1'b1;
        end else if ((!bwd_r && pr_data == bfm_pkg::CMD_CLOSE) ||
                     (bwd_r && pr_data == bfm_pkg::CMD_OPEN)) begin
          depth_nxt = depth_r - 1'b1;
          if (depth_r == LW'(1)) begin
            ip_nxt    = j_r + 1'b1;
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_FETCH;
          end
        end
      end

      S_SUP: begin
        if (pr_data == bfm_pkg::CMD_READ) begin
          tw_en    = 1'b1;
          tw_data  = data_r;
          cell_nxt = data_r;
          ip_nxt   = ip_r + 1'b1;
        end
        state_nxt = S_RESP;
      end

      S_CLEAR: begin
        tw_en   = 1'b1;
        tw_addr = clr_r;
        tw_data = 8'd0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == TAPE_LAST) begin
          tp_nxt    = '0;
          ip_nxt    = '0;
          depth_nxt = '0;
          cell_nxt  = 8'd0;
          state_nxt = clr_resp_r ? S_RESP : S_IDLE;
        end
      end

      S_RESP: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and architectural registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      len_r      <= '0;
      ip_r       <= '0;
      tp_r       <= '0;
      depth_r    <= '0;
      j_r        <= '0;
      bwd_r      <= 1'b0;
      cnt_r      <= '0;
      cell_r     <= 8'd0;
      clr_r      <= '0;
      clr_resp_r <= 1'b0;
      budget_r   <= '0;
    end else begin
      state_r    <= state_nxt;
      len_r      <= len_nxt;
      ip_r       <= ip_nxt;
      tp_r       <= tp_nxt;
      depth_r    <= depth_nxt;
      j_r        <= j_nxt;
      bwd_r      <= bwd_nxt;
      cnt_r      <= cnt_nxt;
      cell_r     <= cell_nxt;
      clr_r      <= clr_nxt;
      clr_resp_r <= clr_resp_nxt;
      if (cfg_we) begin
        budget_r <= cfg_wdata;
      end
    end
  end

  // Payload holding registers.
  always_ff @(posedge clk) begin
    data_r     <= data_nxt;
    res_sts_r  <= res_sts_nxt;
    res_byte_r <= res_byte_nxt;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_sts_r;
      out_byte_r   <= res_byte_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_byte   = out_byte_r;

`ifndef SYNTHESIS
  // The tape pointer never leaves the tape.
  a_tp_range: assert property (@(posedge clk) disable iff (!rst_n)
    tp_r <= TAPE_LAST)
    else $error("tape pointer beyond the tape");

  // The instruction pointer never passes the end of the loaded code.
  a_ip_range: assert property (@(posedge clk) disable iff (!rst_n)
    ip_r <= len_r)
    else $error("instruction pointer beyond code length");

  // The nesting counter is zero outside a bracket scan.
  a_depth_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (depth_r == '0))
    else $error("nesting counter left nonzero");
`endif

endmodule

`default_nettype wire
